// ===== sv/wfh_pkg.sv =====
// ----------------------------------------------------------------------------
// wfh_pkg
// Shared constants and types of the word fingerprint hash unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package wfh_pkg;

  localparam logic [63:0] MulState = 64'hC6A4_A793_5BD1_E995;
  localparam logic [63:0] MulInput = 64'h0228_876A_7198_B743;
  localparam logic [63:0] FpSeed   = 64'hA5B8_5C5E_198E_D849;
  localparam int unsigned MixShift = 47;

  typedef struct packed {
    logic        vld;
    logic        shl;
    logic [31:0] a;
    logic [31:0] b;
  } wfh_mul_req_t;

  typedef struct packed {
    logic        vld;
    logic        shl;
    logic [63:0] p;
  } wfh_mul_rsp_t;

  typedef struct packed {
    logic        start;
    logic [63:0] acc;
    logic [63:0] word;
  } wfh_fold_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] res;
  } wfh_fold_rsp_t;

endpackage

`default_nettype wire

// ===== sv/word_fingerprint_hash_unit.sv =====
// ----------------------------------------------------------------------------
// word_fingerprint_hash_unit
// Streaming 64-bit fingerprint of one word, one byte per input item.
// ----------------------------------------------------------------------------
// Bytes of a word arrive on the input channel (in_valid_i / in_ready_o), one
// item each; an item with last_i set ends the word, and an item with
// no_byte_i set carries no byte, so a lone such item with last_i ends an
// empty word. The fingerprint leaves on the output channel
// (out_valid_o / out_ready_i) from an output register.
// A byte that does not complete a group of eight leaves the input ready. The eighth
// byte of a group starts a mix on the shared 32x32 multiplier: six partial
// products, a drain state to add in the last of them and a mix state, and the
// input is not ready until the mix is done. A last item needs one more mix
// (two after a full group) before its fingerprint goes to the output register.
// While a fingerprint waits in the output register, bytes of the next word
// are still accepted; a later last item is taken too, but then the input
// stays not ready until the output register is free. Reset clears the word
// state to the seed, sets char_is_signed to 1 and empties the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module word_fingerprint_hash_unit
  import wfh_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  byte_value_i,
  input  wire logic        last_i,
  input  wire logic        no_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [63:0]      fingerprint_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_GRP,
    S_FIN,
    S_OUT
  } top_state_e;

  top_state_e    state_q;
  logic          char_is_signed_q;
  logic [63:0]   fp_q;
  logic [63:0]   group_q;
  logic [63:0]   residual_q;
  logic [2:0]    count_q;
  logic          pend_last_q;
  logic          out_valid_q;
  logic [63:0]   fingerprint_q;

  logic          accept;
  logic          take_byte;
  logic          group_full;
  logic [63:0]   ext;
  logic [63:0]   group_nx;
  logic [63:0]   residual_nx;
  wfh_fold_req_t freq;
  wfh_fold_rsp_t frsp;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign take_byte  = accept && !no_byte_i;
  assign group_full = (count_q == 3'd7);

  assign ext         = {{56{char_is_signed_q & byte_value_i[7]}}, byte_value_i};
  assign group_nx    = group_q | ({56'd0, byte_value_i} << {count_q, 3'b000});
  assign residual_nx = {residual_q[55:0], 8'd0} | ext;

  always_comb begin
    freq.start = 1'b0;
    freq.acc   = fp_q;
    freq.word  = residual_q;
    if (take_byte && group_full) begin
      freq.start = 1'b1;
      freq.word  = group_nx;
    end else if (accept && last_i) begin
      freq.start = 1'b1;
      freq.word  = no_byte_i ? residual_q : residual_nx;
    end else if (state_q == S_GRP && frsp.done && pend_last_q) begin
      freq.start = 1'b1;
      freq.acc   = frsp.res;
      freq.word  = 64'd0;
    end
  end

  wfh_fold u_fold (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (freq),
    .rsp_o  (frsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= S_IDLE;
      char_is_signed_q <= 1'b1;
      fp_q             <= FpSeed;
      group_q          <= 64'd0;
      residual_q       <= 64'd0;
      count_q          <= 3'd0;
      pend_last_q      <= 1'b0;
      out_valid_q      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        char_is_signed_q <= cfg_wdata_i;
      end
      if (state_q == S_OUT && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (take_byte && group_full) begin
            group_q     <= 64'd0;
            residual_q  <= 64'd0;
            count_q     <= 3'd0;
            pend_last_q <= last_i;
            state_q     <= S_GRP;
          end else if (accept && last_i) begin
            fp_q       <= FpSeed;
            group_q    <= 64'd0;
            residual_q <= 64'd0;
            count_q    <= 3'd0;
            state_q    <= S_FIN;
          end else if (take_byte) begin
            group_q    <= group_nx;
            residual_q <= residual_nx;
            count_q    <= count_q + 3'd1;
          end
        end
        S_GRP: begin
          if (frsp.done) begin
            if (pend_last_q) begin
              fp_q    <= FpSeed;
              state_q <= S_FIN;
            end else begin
              fp_q    <= frsp.res;
              state_q <= S_IDLE;
            end
          end
        end
        S_FIN: begin
          if (frsp.done) begin
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid_q || out_ready_i) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_OUT && (!out_valid_q || out_ready_i)) begin
      fingerprint_q <= frsp.res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign fingerprint_o = fingerprint_q;

endmodule

`default_nettype wire

// ===== sv/wfh_mul32.sv =====
// ----------------------------------------------------------------------------
// wfh_mul32
// Registered 32x32 multiplier shared by all partial products of the mix.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wfh_mul32
  import wfh_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire wfh_mul_req_t req_i,
  output wfh_mul_rsp_t      rsp_o
);

  logic        vld_q;
  logic        shl_q;
  logic [63:0] p_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= req_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.vld) begin
      shl_q <= req_i.shl;
      p_q   <= {32'd0, req_i.a} * {32'd0, req_i.b};
    end
  end

  assign rsp_o.vld = vld_q;
  assign rsp_o.shl = shl_q;
  assign rsp_o.p   = p_q;

endmodule

`default_nettype wire

// ===== sv/wfh_fold.sv =====
// ----------------------------------------------------------------------------
// wfh_fold
// Mix sequencer: builds acc * MulState + word * MulInput from six partial
// products on the shared multiplier, then adds the inverted sum shifted right.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wfh_fold
  import wfh_pkg::*;
(
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire wfh_fold_req_t req_i,
  output wfh_fold_rsp_t      rsp_o
);

  typedef enum logic [1:0] {
    F_IDLE,
    F_MUL,
    F_DRAIN,
    F_MIX
  } fold_state_e;

  fold_state_e  state_q;
  logic [2:0]   step_q;
  logic [63:0]  acc_q;
  logic [63:0]  word_q;
  logic [63:0]  sum_q;
  logic [63:0]  res_q;
  logic         done_q;
  wfh_mul_req_t mreq;
  wfh_mul_rsp_t mrsp;

  always_comb begin
    mreq.vld = (state_q == F_MUL);
    mreq.shl = 1'b1;
    mreq.a   = acc_q[31:0];
    mreq.b   = MulState[31:0];
    case (step_q)
      3'd0: begin
        mreq.shl = 1'b0;
      end
      3'd1: begin
        mreq.b = MulState[63:32];
      end
      3'd2: begin
        mreq.a = acc_q[63:32];
      end
      3'd3: begin
        mreq.shl = 1'b0;
        mreq.a   = word_q[31:0];
        mreq.b   = MulInput[31:0];
      end
      3'd4: begin
        mreq.a = word_q[31:0];
        mreq.b = MulInput[63:32];
      end
      3'd5: begin
        mreq.a = word_q[63:32];
        mreq.b = MulInput[31:0];
      end
      default: begin
        mreq.vld = 1'b0;
      end
    endcase
  end

  wfh_mul32 u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mreq),
    .rsp_o  (mrsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      step_q  <= 3'd0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        F_IDLE: begin
          if (req_i.start) begin
            state_q <= F_MUL;
            step_q  <= 3'd0;
          end
        end
        F_MUL: begin
          step_q <= step_q + 3'd1;
          if (step_q == 3'd5) begin
            state_q <= F_DRAIN;
          end
        end
        F_DRAIN: begin
          state_q <= F_MIX;
        end
        F_MIX: begin
          state_q <= F_IDLE;
          done_q  <= 1'b1;
        end
        default: begin
          state_q <= F_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == F_IDLE && req_i.start) begin
      acc_q  <= req_i.acc;
      word_q <= req_i.word;
      sum_q  <= 64'd0;
    end else if (mrsp.vld) begin
      sum_q <= sum_q + (mrsp.shl ? {mrsp.p[31:0], 32'd0} : mrsp.p);
    end
    if (state_q == F_MIX) begin
      res_q <= sum_q + ((~sum_q) >> MixShift);
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.res  = res_q;

endmodule

`default_nettype wire

// ===== sv/wfh_checker.sv =====
// ----------------------------------------------------------------------------
// wfh_checker
// Port-level checks of the word fingerprint hash unit, bound to its top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wfh_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic        last_i,
  input wire logic        no_byte_i,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [63:0] fingerprint_o
);

  logic in_acc;

  assign in_acc = in_valid_i && in_ready_o;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("Output item dropped before it was taken.");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(fingerprint_o))
    else $error("Fingerprint changed while the output was stalled.");

  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o)
    else $error("Output valid during reset.");

  a_last_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && last_i |=> !in_ready_o)
    else $error("A last item did not start the final mix.");

  a_skip_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && no_byte_i && !last_i |=> in_ready_o)
    else $error("An item without a byte stalled the input.");

endmodule

bind word_fingerprint_hash_unit wfh_checker u_wfh_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .last_i        (last_i),
  .no_byte_i     (no_byte_i),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .fingerprint_o (fingerprint_o)
);

`default_nettype wire
